### rtl/text_console_writer_core_macros.svh
// Assertion macros shared by the text console writer RTL.
`ifndef TEXT_CONSOLE_WRITER_CORE_MACROS_SVH
`define TEXT_CONSOLE_WRITER_CORE_MACROS_SVH

// Implication checked in the same cycle.
`define TCW_ASSERT_SAME(label, clk, rstn, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error(msg);

// Implication checked in the next cycle.
`define TCW_ASSERT_NEXT(label, clk, rstn, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error(msg);

`endif

### rtl/tcw_pkg.sv
// Types, codes and control word layout for the text console writer.
package tcw_pkg;

    // Operation codes of the func field
    typedef enum logic [1:0] {
        FN_PUT    = 2'd0,
        FN_READ   = 2'd1,
        FN_SETCUR = 2'd2,
        FN_CLEAR  = 2'd3
    } tcw_func_t;

    // Character codes
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [7:0] RESET_ATTR = 8'h07;
    localparam logic [3:0] RESET_FG   = 4'd7;
    localparam logic [3:0] RESET_BG   = 4'd0;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_FOREGROUND = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BACKGROUND = 2'd1;

    typedef struct packed {
        tcw_func_t  func;
        logic [7:0] char_code;
        logic [4:0] target_row;
        logic [6:0] target_column;
    } tcw_in_t;

    typedef struct packed {
        logic [7:0]  cell_char;
        logic [7:0]  cell_attr;
        logic [4:0]  cursor_row_out;
        logic [6:0]  cursor_column_out;
        logic [10:0] cursor_linear;
    } tcw_out_t;

    // Microprogram steps
    typedef enum logic [3:0] {
        ST_INIT      = 4'd0,
        ST_IDLE      = 4'd1,
        ST_PRINT     = 4'd2,
        ST_TAB       = 4'd3,
        ST_NL        = 4'd4,
        ST_CR        = 4'd5,
        ST_BS        = 4'd6,
        ST_BS_WR     = 4'd7,
        ST_READ      = 4'd8,
        ST_SETCUR    = 4'd9,
        ST_CLEAR     = 4'd10,
        ST_SCR_PRIME = 4'd11,
        ST_SCR_COPY  = 4'd12,
        ST_SCR_BLANK = 4'd13,
        ST_FIN       = 4'd14
    } tcw_step_t;

    // Jump conditions
    typedef enum logic [2:0] {
        C_ALWAYS   = 3'd0,
        C_ACCEPT   = 3'd1,
        C_PTR_LAST = 3'd2,
        C_COPY_END = 3'd3,
        C_COL_WRAP = 3'd4,
        C_TAB_WRAP = 3'd5,
        C_LAST_ROW = 3'd6,
        C_OUT_FREE = 3'd7
    } tcw_cond_t;

    // Cell write data select
    typedef enum logic [1:0] {
        W_CHAR  = 2'd0,
        W_BLANK = 2'd1,
        W_RESET = 2'd2,
        W_COPY  = 2'd3
    } tcw_wsel_t;

    // Cell write address select
    typedef enum logic {
        A_CURSOR = 1'b0,
        A_PTR    = 1'b1
    } tcw_asel_t;

    // Sweep pointer operation
    typedef enum logic [1:0] {
        P_HOLD = 2'd0,
        P_ZERO = 2'd1,
        P_INC  = 2'd2
    } tcw_ptr_t;

    // Cursor operation
    typedef enum logic [2:0] {
        U_HOLD   = 3'd0,
        U_ZERO   = 3'd1,
        U_SET    = 3'd2,
        U_CR     = 3'd3,
        U_TAB    = 3'd4,
        U_INC    = 3'd5,
        U_NEWROW = 3'd6,
        U_BS     = 3'd7
    } tcw_cur_t;

    // One control word of the microprogram
    typedef struct packed {
        tcw_cond_t cond;
        tcw_step_t t_true;
        tcw_step_t t_false;
        logic      ready;
        logic      wr_en;
        tcw_wsel_t wsel;
        tcw_asel_t wa_sel;
        logic      rd_src;
        tcw_ptr_t  ptr_op;
        tcw_cur_t  cur_op;
        logic      done;
    } tcw_ctl_t;

    // Datapath flags seen by the sequencer
    typedef struct packed {
        logic out_free;
        logic ptr_last;
        logic copy_end;
        logic col_wrap;
        logic tab_wrap;
        logic last_row;
    } tcw_status_t;

endpackage

### rtl/text_console_writer_core.sv
// Top level of the text console writer: sequencer, datapath and checks.
//
// Text console engine holding a ROWS x COLUMNS grid of 16-bit cells
// (attribute byte over character byte) and a cursor.
// Input channel s_*: one operation per transfer (put character, read cell,
// set cursor, clear screen). Result channel m_*: exactly one result per
// operation, in order, with the cursor after the operation and, for a read,
// the addressed cell.
// Configuration channel cfg_*: always ready; index 0 sets the foreground
// color, index 1 the background color, other indexes are ignored.
// Each operation runs from its entry step to the result step and then back to
// idle, where the next operation is taken; a wrap adds the newline step and a
// backspace adds a blanking write step.
// A newline on the last row scrolls the grid through the single cell memory
// port pair, one cell per cycle, then blanks the last row. Clear screen sweeps
// every cell with a blank.
// Reset: the microprogram first fills every cell with a blank of attribute
// 0x07, while s_ready stays low.
// The result sits in an output register; while the receiver stalls, the next
// operation is still taken and runs up to its result step, where it waits.
`include "text_console_writer_core_macros.svh"

module text_console_writer_core #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  tcw_pkg::tcw_in_t              s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output tcw_pkg::tcw_out_t             m_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tcw_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [3:0]                    cfg_data
);
    import tcw_pkg::*;

    tcw_ctl_t    ctl;
    tcw_status_t status;
    logic        accept;

    assign cfg_ready = 1'b1;

    // Microcode sequencer
    tcw_sequencer u_seq (
        .clk     (aclk),
        .rstn    (aresetn),
        .s_valid (s_valid),
        .s_data  (s_data),
        .status  (status),
        .ctl     (ctl),
        .s_ready (s_ready),
        .accept  (accept)
    );

    // Datapath with cell memory
    tcw_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_dp (
        .clk       (aclk),
        .rstn      (aresetn),
        .ctl       (ctl),
        .accept    (accept),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .status    (status),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // Checks
    `TCW_ASSERT_SAME(a_no_write_idle, aclk, aresetn, s_ready, !ctl.wr_en, "cell write while idle")
    `TCW_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready, "ready held after transfer")
    `TCW_ASSERT_NEXT(a_result_posted, aclk, aresetn, ctl.done && (!m_valid || m_ready), m_valid, "result step did not post")

endmodule

### rtl/tcw_ram.sv
// Generic simple dual-port RAM with registered read.
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/tcw_sequencer.sv
// Microcode sequencer: step counter, control ROM, jump logic and dispatch.
module tcw_sequencer (
    input  logic                clk,
    input  logic                rstn,
    input  logic                s_valid,
    input  tcw_pkg::tcw_in_t    s_data,
    input  tcw_pkg::tcw_status_t status,
    output tcw_pkg::tcw_ctl_t   ctl,
    output logic                s_ready,
    output logic                accept
);
    import tcw_pkg::*;

    tcw_step_t upc_reg, upc_next;
    tcw_ctl_t  word;
    logic      cond_true;

    // Control ROM
    function automatic tcw_ctl_t ucode(input tcw_step_t st);
        tcw_ctl_t w;
        w = '0;
        w.cond    = C_ALWAYS;
        w.t_true  = ST_IDLE;
        w.t_false = ST_IDLE;
        w.wsel    = W_BLANK;
        w.wa_sel  = A_CURSOR;
        w.ptr_op  = P_HOLD;
        w.cur_op  = U_HOLD;
        unique case (st)
            ST_INIT: begin
                w.wr_en = 1'b1; w.wsel = W_RESET; w.wa_sel = A_PTR; w.ptr_op = P_INC;
                w.cond = C_PTR_LAST; w.t_true = ST_IDLE; w.t_false = ST_INIT;
            end
            ST_IDLE: begin
                w.ready = 1'b1; w.ptr_op = P_ZERO;
                w.cond = C_ACCEPT; w.t_true = ST_IDLE; w.t_false = ST_IDLE;
            end
            ST_PRINT: begin
                w.wr_en = 1'b1; w.wsel = W_CHAR; w.cur_op = U_INC;
                w.cond = C_COL_WRAP; w.t_true = ST_NL; w.t_false = ST_FIN;
            end
            ST_TAB: begin
                w.cur_op = U_TAB;
                w.cond = C_TAB_WRAP; w.t_true = ST_NL; w.t_false = ST_FIN;
            end
            ST_NL: begin
                w.cur_op = U_NEWROW;
                w.cond = C_LAST_ROW; w.t_true = ST_SCR_PRIME; w.t_false = ST_FIN;
            end
            ST_CR: begin
                w.cur_op = U_CR; w.t_true = ST_FIN;
            end
            ST_BS: begin
                w.cur_op = U_BS; w.t_true = ST_BS_WR;
            end
            ST_BS_WR: begin
                w.wr_en = 1'b1; w.wsel = W_BLANK; w.t_true = ST_FIN;
            end
            ST_READ: begin
                w.t_true = ST_FIN;
            end
            ST_SETCUR: begin
                w.cur_op = U_SET; w.t_true = ST_FIN;
            end
            ST_CLEAR: begin
                w.wr_en = 1'b1; w.wsel = W_BLANK; w.wa_sel = A_PTR; w.ptr_op = P_INC;
                w.cur_op = U_ZERO;
                w.cond = C_PTR_LAST; w.t_true = ST_FIN; w.t_false = ST_CLEAR;
            end
            ST_SCR_PRIME: begin
                w.rd_src = 1'b1; w.t_true = ST_SCR_COPY;
            end
            ST_SCR_COPY: begin
                w.wr_en = 1'b1; w.wsel = W_COPY; w.wa_sel = A_PTR; w.ptr_op = P_INC;
                w.rd_src = 1'b1;
                w.cond = C_COPY_END; w.t_true = ST_SCR_BLANK; w.t_false = ST_SCR_COPY;
            end
            ST_SCR_BLANK: begin
                w.wr_en = 1'b1; w.wsel = W_BLANK; w.wa_sel = A_PTR; w.ptr_op = P_INC;
                w.cond = C_PTR_LAST; w.t_true = ST_FIN; w.t_false = ST_SCR_BLANK;
            end
            ST_FIN: begin
                w.done = 1'b1;
                w.cond = C_OUT_FREE; w.t_true = ST_IDLE; w.t_false = ST_FIN;
            end
            default: begin
                w.t_true = ST_IDLE;
            end
        endcase
        return w;
    endfunction

    // Entry point of each operation
    function automatic tcw_step_t dispatch(input tcw_in_t d);
        tcw_step_t st;
        st = ST_PRINT;
        unique case (d.func)
            FN_PUT: begin
                unique case (d.char_code)
                    CH_LF:   st = ST_NL;
                    CH_CR:   st = ST_CR;
                    CH_TAB:  st = ST_TAB;
                    CH_BS:   st = ST_BS;
                    default: st = ST_PRINT;
                endcase
            end
            FN_READ:   st = ST_READ;
            FN_SETCUR: st = ST_SETCUR;
            FN_CLEAR:  st = ST_CLEAR;
        endcase
        return st;
    endfunction

    assign word    = ucode(upc_reg);
    assign ctl     = word;
    assign s_ready = word.ready;
    assign accept  = s_valid && word.ready;

    // Condition select
    always_comb begin
        unique case (word.cond)
            C_ALWAYS:   cond_true = 1'b1;
            C_ACCEPT:   cond_true = accept;
            C_PTR_LAST: cond_true = status.ptr_last;
            C_COPY_END: cond_true = status.copy_end;
            C_COL_WRAP: cond_true = status.col_wrap;
            C_TAB_WRAP: cond_true = status.tab_wrap;
            C_LAST_ROW: cond_true = status.last_row;
            C_OUT_FREE: cond_true = status.out_free;
        endcase
    end

    // Next step
    always_comb begin
        if (!cond_true) begin
            upc_next = word.t_false;
        end else if (word.cond == C_ACCEPT) begin
            upc_next = dispatch(s_data);
        end else begin
            upc_next = word.t_true;
        end
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            upc_reg <= ST_INIT;
        end else begin
            upc_reg <= upc_next;
        end
    end

endmodule

### rtl/tcw_datapath.sv
// Datapath: cursor, sweep pointer, color registers, cell memory and result register.
module tcw_datapath #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                           clk,
    input  logic                           rstn,
    input  tcw_pkg::tcw_ctl_t              ctl,
    input  logic                           accept,
    input  tcw_pkg::tcw_in_t               s_data,
    input  logic                           cfg_valid,
    input  logic [tcw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [3:0]                     cfg_data,
    output tcw_pkg::tcw_status_t           status,
    output logic                           m_valid,
    input  logic                           m_ready,
    output tcw_pkg::tcw_out_t              m_data
);
    import tcw_pkg::*;

    localparam int CELLS  = ROWS * COLUMNS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLUMNS);

    localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(ROWS - 1);
    localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(COLUMNS - 1);
    localparam logic [COL_W:0]    COLS_X    = (COL_W + 1)'(COLUMNS);
    localparam logic [ADDR_W-1:0] COLS_AW   = ADDR_W'(COLUMNS);
    localparam logic [ADDR_W:0]   COLS_A    = (ADDR_W + 1)'(COLUMNS);
    localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] COPY_LAST = ADDR_W'((ROWS - 1) * COLUMNS - 1);
    localparam logic [7:0]        ROWS_8    = 8'(ROWS);
    localparam logic [8:0]        COLS_9    = 9'(COLUMNS);

    logic [ROW_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ADDR_W-1:0] ptr_reg, ptr_next;
    logic [3:0]        fg_reg, fg_next;
    logic [3:0]        bg_reg, bg_next;
    logic              m_valid_reg, m_valid_next;
    tcw_in_t           op_reg;
    tcw_out_t          m_data_reg, m_data_next;

    logic [7:0]        trow_x;
    logic [8:0]        tcol_x;
    logic [ROW_W-1:0]  row_tgt;
    logic [COL_W-1:0]  col_tgt;
    logic [ADDR_W-1:0] tgt_addr, cur_addr;
    logic [COL_W:0]    col_inc, tab_sum, tab_col;
    logic [ADDR_W:0]   src_sum;
    logic [7:0]        attr;
    logic              load;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [15:0]       ram_wdata, ram_rdata;
    logic [ROW_W+4:0]  row_ext;
    logic [COL_W+6:0]  col_ext;
    logic [ADDR_W+10:0] lin_ext;

    // Target clamp and cell addresses
    assign trow_x   = {3'b000, op_reg.target_row};
    assign tcol_x   = {2'b00, op_reg.target_column};
    assign row_tgt  = (trow_x >= ROWS_8) ? LAST_ROW : trow_x[ROW_W-1:0];
    assign col_tgt  = (tcol_x >= COLS_9) ? LAST_COL : tcol_x[COL_W-1:0];
    assign tgt_addr = ADDR_W'(row_tgt) * COLS_AW + ADDR_W'(col_tgt);
    assign cur_addr = ADDR_W'(row_reg) * COLS_AW + ADDR_W'(col_reg);

    // Column arithmetic
    assign col_inc = (COL_W + 1)'(col_reg) + (COL_W + 1)'(1);
    assign tab_sum = (COL_W + 1)'(col_reg) + (COL_W + 1)'(4);
    assign tab_col = {tab_sum[COL_W:2], 2'b00};

    // Flags for the sequencer
    assign status.out_free = !m_valid_reg || m_ready;
    assign status.ptr_last = (ptr_reg == LAST_CELL);
    assign status.copy_end = (ptr_reg == COPY_LAST);
    assign status.col_wrap = (col_inc == COLS_X);
    assign status.tab_wrap = (tab_col >= COLS_X);
    assign status.last_row = (row_reg == LAST_ROW);

    // Cursor update
    always_comb begin
        row_next = row_reg;
        col_next = col_reg;
        unique case (ctl.cur_op)
            U_HOLD: begin
            end
            U_ZERO: begin
                row_next = '0;
                col_next = '0;
            end
            U_SET: begin
                row_next = row_tgt;
                col_next = col_tgt;
            end
            U_CR: begin
                col_next = '0;
            end
            U_TAB: begin
                col_next = tab_col[COL_W-1:0];
            end
            U_INC: begin
                col_next = col_inc[COL_W-1:0];
            end
            U_NEWROW: begin
                col_next = '0;
                if (row_reg != LAST_ROW) begin
                    row_next = row_reg + ROW_W'(1);
                end
            end
            U_BS: begin
                if (col_reg != '0) begin
                    col_next = col_reg - COL_W'(1);
                end else if (row_reg != '0) begin
                    row_next = row_reg - ROW_W'(1);
                    col_next = LAST_COL;
                end
            end
        endcase
    end

    // Sweep pointer
    always_comb begin
        unique case (ctl.ptr_op)
            P_HOLD:  ptr_next = ptr_reg;
            P_ZERO:  ptr_next = '0;
            P_INC:   ptr_next = ptr_reg + ADDR_W'(1);
            default: ptr_next = ptr_reg;
        endcase
    end

    // Color registers
    always_comb begin
        fg_next = fg_reg;
        bg_next = bg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_FOREGROUND: fg_next = cfg_data;
                REG_BACKGROUND: bg_next = cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Cell memory write and read ports
    assign attr    = {bg_reg, fg_reg};
    assign ram_we  = ctl.wr_en;
    assign src_sum = (ADDR_W + 1)'(ptr_next) + COLS_A;

    always_comb begin
        unique case (ctl.wsel)
            W_CHAR:  ram_wdata = {attr, op_reg.char_code};
            W_BLANK: ram_wdata = {attr, CH_SPACE};
            W_RESET: ram_wdata = {RESET_ATTR, CH_SPACE};
            W_COPY:  ram_wdata = ram_rdata;
        endcase
    end

    always_comb begin
        unique case (ctl.wa_sel)
            A_CURSOR: ram_waddr = cur_addr;
            A_PTR:    ram_waddr = ptr_reg;
        endcase
    end

    assign ram_raddr = ctl.rd_src ? src_sum[ADDR_W-1:0] : tgt_addr;

    tcw_ram #(
        .WIDTH (16),
        .DEPTH (CELLS)
    ) u_cells (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Result register
    assign load    = ctl.done && status.out_free;
    assign row_ext = {5'b0, row_reg};
    assign col_ext = {7'b0, col_reg};
    assign lin_ext = {11'b0, cur_addr};

    always_comb begin
        m_data_next.cell_char         = (op_reg.func == FN_READ) ? ram_rdata[7:0] : 8'h00;
        m_data_next.cell_attr         = (op_reg.func == FN_READ) ? ram_rdata[15:8] : 8'h00;
        m_data_next.cursor_row_out    = row_ext[4:0];
        m_data_next.cursor_column_out = col_ext[6:0];
        m_data_next.cursor_linear     = lin_ext[10:0];
    end

    always_comb begin
        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // Control state
    always_ff @(posedge clk) begin
        if (!rstn) begin
            row_reg     <= '0;
            col_reg     <= '0;
            ptr_reg     <= '0;
            fg_reg      <= RESET_FG;
            bg_reg      <= RESET_BG;
            m_valid_reg <= 1'b0;
        end else begin
            row_reg     <= row_next;
            col_reg     <= col_next;
            ptr_reg     <= ptr_next;
            fg_reg      <= fg_next;
            bg_reg      <= bg_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk) begin
        if (accept) begin
            op_reg <= s_data;
        end
        if (load) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
